@@ src/ppbsl_pkg.sv @@
// shared types and constants for the path point blend and segment length unit
`default_nettype none
package ppbsl_pkg;

  // fixed point format and field widths
  localparam int FRAC_BITS = 12;
  localparam int WEIGHT_W  = 13;
  localparam int DATA_W    = 32;
  localparam int LEN_W     = 31;
  localparam int SUM_W     = 2 * DATA_W;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = DATA_W + FRAC_BITS + 2;
  localparam int STEP_W    = 3;

  localparam logic [WEIGHT_W-1:0] ONE_Q        = WEIGHT_W'(1 << FRAC_BITS);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = ONE_Q;
  localparam logic [LEN_W-1:0]    LEN_MAX      = {LEN_W{1'b1}};

  // multiply sequence steps
  localparam logic [STEP_W-1:0] STEP_BX  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_AX  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BY  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_AY  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SQX = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SQZ = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SQY = 3'd6;
  localparam logic [STEP_W-1:0] STEP_SUM = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic                     first_point;
    logic signed [DATA_W-1:0] point_a_x;
    logic signed [DATA_W-1:0] point_a_y;
    logic signed [DATA_W-1:0] point_b_x;
    logic signed [DATA_W-1:0] point_b_y;
    logic signed [DATA_W-1:0] point_b_z;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] seg_dx;
    logic signed [DATA_W-1:0] seg_dy;
    logic signed [DATA_W-1:0] seg_dz;
    logic        [LEN_W-1:0]  seg_length;
  } out_word_t;

endpackage
`default_nettype wire

@@ src/path_point_blend_and_segment_length_unit.sv @@
// top level: point blend, segment vector and bit-serial segment length
`default_nettype none
// Each input word is one polyline point given as two Q12 source points A and
// B. X and Y are blended with the blend_weight register, Z is taken from B,
// and for every point not marked first_point one output word carries the
// segment vector (previous minus current) and its floor length, saturated to
// 31 bits. Before the next point can be accepted, a point goes through 8
// steps of one shared 33 x 33 multiplier for the blend and the three
// squares, 32 steps of the bit-serial square root, and a load state that
// puts any output word into the output register. A finished
// word waits in the output register while the next point is being worked on.
// Write blend_weight only while no point is in flight.
module path_point_blend_and_segment_length_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ppbsl_pkg::in_word_t               in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ppbsl_pkg::out_word_t              out_word,
  input  logic                              cfg_we,
  input  logic [ppbsl_pkg::WEIGHT_W-1:0]    cfg_data
);
  import ppbsl_pkg::*;

  state_t                     state;
  state_t                     state_next;
  logic [STEP_W-1:0]          step;
  logic [WEIGHT_W-1:0]        weight;
  logic                       first;

  logic [DATA_W-1:0]          prev_x;
  logic [DATA_W-1:0]          prev_y;
  logic [DATA_W-1:0]          prev_z;
  logic [DATA_W-1:0]          ax;
  logic [DATA_W-1:0]          ay;
  logic [DATA_W-1:0]          bx;
  logic [DATA_W-1:0]          by;
  logic [DATA_W-1:0]          cx;
  logic [DATA_W-1:0]          cy;
  logic [DATA_W-1:0]          dx;
  logic [DATA_W-1:0]          dy;
  logic [DATA_W-1:0]          dz;

  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]           sum;
  logic [SUM_W-1:0]           rem;
  logic [SUM_W-1:0]           root;
  logic [SUM_W-1:0]           bitv;

  logic [WEIGHT_W-1:0]        w_a;
  logic [WEIGHT_W-1:0]        w_b;
  logic [MUL_W-1:0]           op_a;
  logic [MUL_W-1:0]           op_b;
  logic signed [ACC_W-1:0]    blend_sum;
  logic [DATA_W-1:0]          blend_val;
  logic [SUM_W-1:0]           trial;
  logic                       in_take;
  logic                       out_take;
  logic                       out_load;
  logic [LEN_W-1:0]           len_sat;

  // magnitude of a signed 32-bit value, as a non-negative 33-bit operand
  function automatic logic [MUL_W-1:0] mag(input logic [DATA_W-1:0] d);
    logic [MUL_W-1:0] sx;
    sx = {d[DATA_W-1], d};
    return d[DATA_W-1] ? (~sx + MUL_W'(1)) : sx;
  endfunction

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  // weight clamp: anything at or above one selects A
  assign w_a = (weight >= ONE_Q) ? ONE_Q : weight;
  assign w_b = ONE_Q - w_a;

  // shared multiplier operand select
  always_comb begin
    case (step)
      STEP_BX: begin
        op_a = {{(MUL_W-WEIGHT_W){1'b0}}, w_b};
        op_b = {bx[DATA_W-1], bx};
      end
      STEP_AX: begin
        op_a = {{(MUL_W-WEIGHT_W){1'b0}}, w_a};
        op_b = {ax[DATA_W-1], ax};
      end
      STEP_BY: begin
        op_a = {{(MUL_W-WEIGHT_W){1'b0}}, w_b};
        op_b = {by[DATA_W-1], by};
      end
      STEP_AY: begin
        op_a = {{(MUL_W-WEIGHT_W){1'b0}}, w_a};
        op_b = {ay[DATA_W-1], ay};
      end
      STEP_SQX: begin
        op_a = mag(dx);
        op_b = mag(dx);
      end
      STEP_SQZ: begin
        op_a = mag(dz);
        op_b = mag(dz);
      end
      STEP_SQY: begin
        op_a = mag(dy);
        op_b = mag(dy);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // blend result: floor shift is a plain bit select of the two's complement sum
  assign blend_sum = acc + prod[ACC_W-1:0];
  assign blend_val = blend_sum[FRAC_BITS+DATA_W-1:FRAC_BITS];

  // one square root step
  assign trial = root + bitv;

  // length saturation
  assign len_sat = (root > SUM_W'(LEN_MAX)) ? LEN_MAX : root[LEN_W-1:0];

  // sequencer next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (step == STEP_SUM) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (bitv[0]) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (first) begin
          state_next = S_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers and kept point
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_BX;
      weight    <= WEIGHT_RESET;
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_z    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        weight <= cfg_data;
      end
      if (in_take) begin
        step   <= STEP_BX;
        prev_z <= in_word.point_b_z;
      end else if (state == S_MUL) begin
        step <= step + STEP_W'(1);
      end
      if (state == S_MUL && step == STEP_AY) begin
        prev_x <= cx;
      end
      if (state == S_MUL && step == STEP_SQZ) begin
        prev_y <= cy;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= $signed(op_a) * $signed(op_b);
    if (in_take) begin
      first <= in_word.first_point;
      ax    <= in_word.point_a_x;
      ay    <= in_word.point_a_y;
      bx    <= in_word.point_b_x;
      by    <= in_word.point_b_y;
      dz    <= prev_z - in_word.point_b_z;
    end
    if (state == S_MUL) begin
      case (step)
        STEP_AX: begin
          acc <= prod[ACC_W-1:0];
        end
        STEP_BY: begin
          cx <= blend_val;
        end
        STEP_AY: begin
          acc <= prod[ACC_W-1:0];
          dx  <= prev_x - cx;
        end
        STEP_SQX: begin
          cy <= blend_val;
        end
        STEP_SQZ: begin
          dy  <= prev_y - cy;
          sum <= prod[SUM_W-1:0];
        end
        STEP_SQY: begin
          sum <= sum + prod[SUM_W-1:0];
        end
        STEP_SUM: begin
          rem  <= sum + prod[SUM_W-1:0];
          root <= '0;
          bitv <= SUM_W'(1) << (SUM_W - 2);
        end
        default: begin
        end
      endcase
    end
    if (state == S_SQRT) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (out_load) begin
      out_word.seg_dx     <= dx;
      out_word.seg_dy     <= dy;
      out_word.seg_dz     <= dz;
      out_word.seg_length <= len_sat;
    end
  end

  // checks
  a_take_starts_mul: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_MUL && step == STEP_BX))
    else $error("accepted word did not start the multiply sequence");

  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> $onehot(bitv))
    else $error("square root bit lost its single set bit");

  a_sqrt_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && bitv[0]) |=> (state == S_LOAD))
    else $error("square root did not end in load");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_LOAD && !first))
    else $error("output word raised outside load");

endmodule
`default_nettype wire
